/* design/lab_pkg.sv */
// shared constants, row codes and helpers for the look-at basis block
`timescale 1ns / 1ps
package lab_pkg;

   localparam int FRAC_DEFAULT = 16;
   localparam int MAG_W        = 31;
   localparam int SQ_W         = 64;
   localparam int ROOT_W       = 32;
   localparam int SQRT_STEPS   = 32;

   typedef enum logic [1:0] {
      ROW_X   = 2'd0,
      ROW_Y   = 2'd1,
      ROW_Z   = 2'd2,
      ROW_EYE = 2'd3
   } row_type;

   function automatic logic [3:0] bit_len8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         if (v[i]) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

/* design/lab_sqrt.sv */
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module lab_sqrt import lab_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [SQ_W-1:0]   in_val,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [1:SQRT_STEPS];
   logic [SQ_W-1:0]   x_ff     [1:SQRT_STEPS];
   logic [SQ_W-1:0]   r_ff     [1:SQRT_STEPS];
   logic [SIDE_W-1:0] side_ff  [1:SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      logic              vc;
      logic [SQ_W-1:0]   xc;
      logic [SQ_W-1:0]   rc;
      logic [SIDE_W-1:0] sc;
      logic [SQ_W-1:0]   t;
      logic [SQ_W-1:0]   x_in;
      logic [SQ_W-1:0]   r_in;

      if (k == 0) begin : g_first
         assign vc = in_valid;
         assign xc = in_val;
         assign rc = '0;
         assign sc = in_side;
      end else begin : g_next
         assign vc = valid_ff[k];
         assign xc = x_ff[k];
         assign rc = r_ff[k];
         assign sc = side_ff[k];
      end

      always_comb begin
         t = rc + BIT;
         if (xc >= t) begin
            x_in = xc - t;
            r_in = (rc >> 1) + BIT;
         end else begin
            x_in = xc;
            r_in = rc >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= vc;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[k+1]    <= x_in;
            r_ff[k+1]    <= r_in;
            side_ff[k+1] <= sc;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS];
   assign out_root  = r_ff[SQRT_STEPS][ROOT_W-1:0];
   assign out_side  = side_ff[SQRT_STEPS];

endmodule

/* design/lab_div.sv */
// three-lane pipelined restoring divider sharing one divisor
`timescale 1ns / 1ps
module lab_div import lab_pkg::*; #(
   parameter int FRAC_BITS = FRAC_DEFAULT,
   parameter int SIDE_W    = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic [3*(MAG_W+FRAC_BITS+1)-1:0]     in_num,
   input  logic [ROOT_W-1:0]                    in_len,
   input  logic [SIDE_W-1:0]                    in_side,
   output logic                                 out_valid,
   output logic [3*(FRAC_BITS+1)-1:0]           out_quo,
   output logic [SIDE_W-1:0]                    out_side
);

   localparam int QW = FRAC_BITS + 1;
   localparam int NW = MAG_W + FRAC_BITS + 1;

   logic                  valid_ff [1:QW];
   logic [3*ROOT_W-1:0]   rem_ff   [1:QW];
   logic [3*QW-1:0]       low_ff   [1:QW];
   logic [3*QW-1:0]       quo_ff   [1:QW];
   logic [ROOT_W-1:0]     len_ff   [1:QW];
   logic [SIDE_W-1:0]     side_ff  [1:QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic                vc;
      logic [3*ROOT_W-1:0] rc;
      logic [3*QW-1:0]     lc;
      logic [3*QW-1:0]     qc;
      logic [ROOT_W-1:0]   dc;
      logic [SIDE_W-1:0]   sc;
      logic [3*ROOT_W-1:0] rem_in;
      logic [3*QW-1:0]     low_in;
      logic [3*QW-1:0]     quo_in;

      if (k == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               rc[i*ROOT_W +: ROOT_W] = ROOT_W'(in_num[i*NW+QW +: NW-QW]);
               lc[i*QW +: QW]         = in_num[i*NW +: QW];
            end
         end
         assign vc = in_valid;
         assign qc = '0;
         assign dc = in_len;
         assign sc = in_side;
      end else begin : g_next
         assign vc = valid_ff[k];
         assign rc = rem_ff[k];
         assign lc = low_ff[k];
         assign qc = quo_ff[k];
         assign dc = len_ff[k];
         assign sc = side_ff[k];
      end

      always_comb begin
         logic [ROOT_W:0] r2;
         logic            ge;
         for (int i = 0; i < 3; i++) begin
            r2 = {rc[i*ROOT_W +: ROOT_W], lc[i*QW+QW-1]};
            ge = (r2 >= {1'b0, dc});
            rem_in[i*ROOT_W +: ROOT_W] = ge ? ROOT_W'(r2 - {1'b0, dc}) : r2[ROOT_W-1:0];
            low_in[i*QW +: QW] = {lc[i*QW +: QW-1], 1'b0};
            quo_in[i*QW +: QW] = {qc[i*QW +: QW-1], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= vc;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= rem_in;
            low_ff[k+1]  <= low_in;
            quo_ff[k+1]  <= quo_in;
            len_ff[k+1]  <= dc;
            side_ff[k+1] <= sc;
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

/* design/lab_norm.sv */
// vector normalisation: scale, sum of squares, root, three divisions
`timescale 1ns / 1ps
module lab_norm import lab_pkg::*; #(
   parameter int FRAC_BITS = FRAC_DEFAULT,
   parameter int VW        = 33,
   parameter int SIDE_W    = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [3*VW-1:0]              in_vec,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [3*(FRAC_BITS+2)-1:0]   out_vec,
   output logic                         out_ok,
   output logic [SIDE_W-1:0]            out_side
);

   localparam int OW    = FRAC_BITS + 2;
   localparam int QW    = FRAC_BITS + 1;
   localparam int NW    = MAG_W + FRAC_BITS + 1;
   localparam int NG    = (VW + 7) / 8;
   localparam int GW    = NG * 8;
   localparam int BLW   = 7;
   localparam int SQ_SW = 3 * MAG_W + 4 + SIDE_W;
   localparam int DV_SW = 4 + SIDE_W;

   // stage a: sign and magnitude
   logic              a_valid_ff;
   logic [VW-1:0]     a_mag_ff [3];
   logic [VW-1:0]     a_mag_in [3];
   logic [2:0]        a_neg_ff;
   logic [2:0]        a_neg_in;
   logic [SIDE_W-1:0] a_side_ff;

   always_comb begin
      logic [VW-1:0] v;
      for (int i = 0; i < 3; i++) begin
         v           = in_vec[i*VW +: VW];
         a_neg_in[i] = v[VW-1];
         a_mag_in[i] = v[VW-1] ? (~v + 1'b1) : v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         a_side_ff <= in_side;
      end
   end

   // stage b: bit length per byte group of the or of all magnitudes
   logic              b_valid_ff;
   logic [NG-1:0]     b_nz_ff;
   logic [NG-1:0]     b_nz_in;
   logic [3:0]        b_len_ff [NG];
   logic [3:0]        b_len_in [NG];
   logic [VW-1:0]     b_mag_ff [3];
   logic [2:0]        b_neg_ff;
   logic [SIDE_W-1:0] b_side_ff;

   always_comb begin
      logic [GW-1:0] orp;
      orp = GW'(a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2]);
      for (int g = 0; g < NG; g++) begin
         b_nz_in[g]  = |orp[g*8 +: 8];
         b_len_in[g] = bit_len8(orp[g*8 +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_nz_ff   <= b_nz_in;
         b_len_ff  <= b_len_in;
         b_mag_ff  <= a_mag_ff;
         b_neg_ff  <= a_neg_ff;
         b_side_ff <= a_side_ff;
      end
   end

   // stage c: bit length of the largest magnitude
   logic              c_valid_ff;
   logic [BLW-1:0]    c_bl_ff;
   logic [BLW-1:0]    c_bl_in;
   logic              c_zero_ff;
   logic [VW-1:0]     c_mag_ff [3];
   logic [2:0]        c_neg_ff;
   logic [SIDE_W-1:0] c_side_ff;

   always_comb begin
      c_bl_in = '0;
      for (int g = 0; g < NG; g++) begin
         if (b_nz_ff[g]) begin
            c_bl_in = BLW'(g * 8) + BLW'(b_len_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_bl_ff   <= c_bl_in;
         c_zero_ff <= ~|b_nz_ff;
         c_mag_ff  <= b_mag_ff;
         c_neg_ff  <= b_neg_ff;
         c_side_ff <= b_side_ff;
      end
   end

   // stage d: common shift so the largest lies just below 2^31
   logic              d_valid_ff;
   logic [MAG_W-1:0]  d_m_ff [3];
   logic [MAG_W-1:0]  d_m_in [3];
   logic              d_zero_ff;
   logic [2:0]        d_neg_ff;
   logic [SIDE_W-1:0] d_side_ff;

   always_comb begin
      logic [SQ_W-1:0] ext;
      logic [SQ_W-1:0] sh;
      for (int i = 0; i < 3; i++) begin
         ext = SQ_W'(c_mag_ff[i]);
         if (c_bl_ff < BLW'(MAG_W)) begin
            sh = ext << (BLW'(MAG_W) - c_bl_ff);
         end else begin
            sh = ext >> (c_bl_ff - BLW'(MAG_W));
         end
         d_m_in[i] = sh[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_m_ff    <= d_m_in;
         d_zero_ff <= c_zero_ff;
         d_neg_ff  <= c_neg_ff;
         d_side_ff <= c_side_ff;
      end
   end

   // stage e: squares
   logic                e_valid_ff;
   logic [2*MAG_W-1:0]  e_sq_ff [3];
   logic [MAG_W-1:0]    e_m_ff  [3];
   logic                e_zero_ff;
   logic [2:0]          e_neg_ff;
   logic [SIDE_W-1:0]   e_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            e_sq_ff[i] <= d_m_ff[i] * d_m_ff[i];
         end
         e_m_ff    <= d_m_ff;
         e_zero_ff <= d_zero_ff;
         e_neg_ff  <= d_neg_ff;
         e_side_ff <= d_side_ff;
      end
   end

   // stage f: sum of squares
   logic             f_valid_ff;
   logic [SQ_W-1:0]  f_sum_ff;
   logic [SQ_SW-1:0] f_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_sum_ff  <= SQ_W'(e_sq_ff[0]) + SQ_W'(e_sq_ff[1]) + SQ_W'(e_sq_ff[2]);
         f_side_ff <= {e_side_ff, e_zero_ff, e_neg_ff, e_m_ff[2], e_m_ff[1], e_m_ff[0]};
      end
   end

   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [SQ_SW-1:0]  sq_side;

   lab_sqrt #(
      .SIDE_W (SQ_SW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f_valid_ff),
      .in_val    (f_sum_ff),
      .in_side   (f_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage g: rounded dividends
   logic              g_valid_ff;
   logic [3*NW-1:0]   g_num_ff;
   logic [3*NW-1:0]   g_num_in;
   logic [ROOT_W-1:0] g_len_ff;
   logic [ROOT_W-1:0] g_len_in;
   logic [DV_SW-1:0]  g_side_ff;
   logic              sq_zero;

   assign sq_zero = sq_side[3*MAG_W+3];

   always_comb begin
      g_len_in = (sq_zero || sq_root == '0) ? ROOT_W'(1) : sq_root;
      for (int i = 0; i < 3; i++) begin
         g_num_in[i*NW +: NW] = {1'b0, sq_side[i*MAG_W +: MAG_W], {FRAC_BITS{1'b0}}}
                              + NW'(g_len_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (advance) begin
         g_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         g_num_ff  <= g_num_in;
         g_len_ff  <= g_len_in;
         g_side_ff <= sq_side[SQ_SW-1:3*MAG_W];
      end
   end

   logic              dv_valid;
   logic [3*QW-1:0]   dv_quo;
   logic [DV_SW-1:0]  dv_side;

   lab_div #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (DV_SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (g_valid_ff),
      .in_num    (g_num_ff),
      .in_len    (g_len_ff),
      .in_side   (g_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // stage h: signs back on, zero vector forced to zero
   logic              h_valid_ff;
   logic [3*OW-1:0]   h_vec_ff;
   logic [3*OW-1:0]   h_vec_in;
   logic              h_ok_ff;
   logic [SIDE_W-1:0] h_side_ff;

   always_comb begin
      logic [OW-1:0] qv;
      for (int i = 0; i < 3; i++) begin
         qv = {1'b0, dv_quo[i*QW +: QW]};
         if (dv_side[3]) begin
            h_vec_in[i*OW +: OW] = '0;
         end else if (dv_side[i]) begin
            h_vec_in[i*OW +: OW] = -qv;
         end else begin
            h_vec_in[i*OW +: OW] = qv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (advance) begin
         h_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h_vec_ff  <= h_vec_in;
         h_ok_ff   <= ~dv_side[3];
         h_side_ff <= dv_side[DV_SW-1:4];
      end
   end

   assign out_valid = h_valid_ff;
   assign out_vec   = h_vec_ff;
   assign out_ok    = h_ok_ff;
   assign out_side  = h_side_ff;

endmodule

/* design/look_at_basis_matrix.sv */
// top level: look-at basis matrix in signed fixed point, streamed out as four rows
`timescale 1ns / 1ps
// Takes eye, target and up in signed fixed point and returns the rows x axis,
// y axis, z axis and eye, in that order, one row per output item, with tlast on
// the eye row. Every stage of the datapath is pipelined, so a new item can be
// taken each cycle the pipe moves; the single output channel carries four rows
// per item, so the output channel, not the datapath, sets the sustained rate.
// The bulk of the pipeline is the two 32-step square roots and the two
// FRAC_BITS+1-step dividers.
// A zero-length z or x axis gives zero rows for the affected axes and sets the
// degenerate flag on all four rows. Backpressure on the output stalls the whole
// pipe without losing items.
module look_at_basis_matrix import lab_pkg::*; #(
   parameter int FRAC_BITS = FRAC_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // col_zero, col_one, col_two, col_three, zero pad
   output logic [119:0] rsp_tdata,
   // row_index, degenerate
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int OW   = FRAC_BITS + 2;
   localparam int DW   = 33;
   localparam int PW1  = 32 + OW;
   localparam int CW   = PW1 + 1;
   localparam int PW2  = 2 * OW;
   localparam int YW2  = PW2 + 1;
   localparam int YW   = FRAC_BITS + 3;
   localparam int S1W  = 192;
   localparam int S2W  = 96 + 3 * OW + 1;
   localparam logic [40:0] UNIT_WIDE = 41'd1 << FRAC_BITS;
   localparam logic [YW2-1:0] HALF = YW2'(1) << (FRAC_BITS - 1);

   logic advance;
   logic load;

   // input register
   logic         s0_valid_ff;
   logic [287:0] s0_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_data_ff <= req_tdata;
      end
   end

   // target minus eye at full width
   logic                 s1_valid_ff;
   logic [3*DW-1:0]      s1_d_ff;
   logic [3*DW-1:0]      s1_d_in;
   logic [S1W-1:0]       s1_side_ff;

   always_comb begin
      logic signed [DW-1:0] e;
      logic signed [DW-1:0] t;
      for (int i = 0; i < 3; i++) begin
         e = DW'($signed(s0_data_ff[i*32 +: 32]));
         t = DW'($signed(s0_data_ff[96+i*32 +: 32]));
         s1_d_in[i*DW +: DW] = t - e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_d_ff    <= s1_d_in;
         s1_side_ff <= {s0_data_ff[287:192], s0_data_ff[95:0]};
      end
   end

   logic            n1_valid;
   logic [3*OW-1:0] n1_z;
   logic            n1_ok;
   logic [S1W-1:0]  n1_side;

   lab_norm #(
      .FRAC_BITS (FRAC_BITS),
      .VW        (DW),
      .SIDE_W    (S1W)
   ) u_norm_z (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .in_vec    (s1_d_ff),
      .in_side   (s1_side_ff),
      .out_valid (n1_valid),
      .out_vec   (n1_z),
      .out_ok    (n1_ok),
      .out_side  (n1_side)
   );

   // cross(up, z): products
   logic                   p1_valid_ff;
   logic signed [PW1-1:0]  p1_prod_ff [6];
   logic signed [PW1-1:0]  p1_prod_in [6];
   logic [S2W-1:0]         p1_side_ff;

   always_comb begin
      logic signed [31:0]   u [3];
      logic signed [OW-1:0] z [3];
      for (int i = 0; i < 3; i++) begin
         u[i] = $signed(n1_side[96+i*32 +: 32]);
         z[i] = $signed(n1_z[i*OW +: OW]);
      end
      p1_prod_in[0] = u[1] * z[2];
      p1_prod_in[1] = u[2] * z[1];
      p1_prod_in[2] = u[2] * z[0];
      p1_prod_in[3] = u[0] * z[2];
      p1_prod_in[4] = u[0] * z[1];
      p1_prod_in[5] = u[1] * z[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= n1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_prod_ff <= p1_prod_in;
         p1_side_ff <= {~n1_ok, n1_z, n1_side[95:0]};
      end
   end

   // cross(up, z): differences
   logic           p2_valid_ff;
   logic [3*CW-1:0] p2_c_ff;
   logic [3*CW-1:0] p2_c_in;
   logic [S2W-1:0] p2_side_ff;

   always_comb begin
      logic signed [CW-1:0] a;
      logic signed [CW-1:0] b;
      for (int i = 0; i < 3; i++) begin
         a = p1_prod_ff[2*i];
         b = p1_prod_ff[2*i+1];
         p2_c_in[i*CW +: CW] = a - b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_c_ff    <= p2_c_in;
         p2_side_ff <= p1_side_ff;
      end
   end

   logic            n2_valid;
   logic [3*OW-1:0] n2_x;
   logic            n2_ok;
   logic [S2W-1:0]  n2_side;

   lab_norm #(
      .FRAC_BITS (FRAC_BITS),
      .VW        (CW),
      .SIDE_W    (S2W)
   ) u_norm_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p2_valid_ff),
      .in_vec    (p2_c_ff),
      .in_side   (p2_side_ff),
      .out_valid (n2_valid),
      .out_vec   (n2_x),
      .out_ok    (n2_ok),
      .out_side  (n2_side)
   );

   // cross(z, x): products
   logic                   q1_valid_ff;
   logic signed [PW2-1:0]  q1_prod_ff [6];
   logic signed [PW2-1:0]  q1_prod_in [6];
   logic [95:0]            q1_eye_ff;
   logic [3*OW-1:0]        q1_z_ff;
   logic [3*OW-1:0]        q1_x_ff;
   logic                   q1_deg_ff;

   always_comb begin
      logic signed [OW-1:0] z [3];
      logic signed [OW-1:0] x [3];
      for (int i = 0; i < 3; i++) begin
         z[i] = $signed(n2_side[96+i*OW +: OW]);
         x[i] = $signed(n2_x[i*OW +: OW]);
      end
      q1_prod_in[0] = z[1] * x[2];
      q1_prod_in[1] = z[2] * x[1];
      q1_prod_in[2] = z[2] * x[0];
      q1_prod_in[3] = z[0] * x[2];
      q1_prod_in[4] = z[0] * x[1];
      q1_prod_in[5] = z[1] * x[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
      end else if (advance) begin
         q1_valid_ff <= n2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_prod_ff <= q1_prod_in;
         q1_eye_ff  <= n2_side[95:0];
         q1_z_ff    <= n2_side[96 +: 3*OW];
         q1_x_ff    <= n2_x;
         q1_deg_ff  <= n2_side[S2W-1] | ~n2_ok;
      end
   end

   // cross(z, x): differences
   logic                  q2_valid_ff;
   logic signed [YW2-1:0] q2_y_ff [3];
   logic signed [YW2-1:0] q2_y_in [3];
   logic [95:0]           q2_eye_ff;
   logic [3*OW-1:0]       q2_z_ff;
   logic [3*OW-1:0]       q2_x_ff;
   logic                  q2_deg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q2_y_in[i] = YW2'(q1_prod_ff[2*i]) - YW2'(q1_prod_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q2_valid_ff <= 1'b0;
      end else if (advance) begin
         q2_valid_ff <= q1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q2_y_ff   <= q2_y_in;
         q2_eye_ff <= q1_eye_ff;
         q2_z_ff   <= q1_z_ff;
         q2_x_ff   <= q1_x_ff;
         q2_deg_ff <= q1_deg_ff;
      end
   end

   // rounding: magnitude plus half
   logic            q3_valid_ff;
   logic [YW2-1:0]  q3_rnd_ff [3];
   logic [YW2-1:0]  q3_rnd_in [3];
   logic [2:0]      q3_neg_ff;
   logic [95:0]     q3_eye_ff;
   logic [3*OW-1:0] q3_z_ff;
   logic [3*OW-1:0] q3_x_ff;
   logic            q3_deg_ff;

   always_comb begin
      logic [YW2-1:0] mag;
      for (int i = 0; i < 3; i++) begin
         mag          = q2_y_ff[i][YW2-1] ? YW2'(-q2_y_ff[i]) : YW2'(q2_y_ff[i]);
         q3_rnd_in[i] = mag + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q3_valid_ff <= 1'b0;
      end else if (advance) begin
         q3_valid_ff <= q2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q3_rnd_ff <= q3_rnd_in;
         for (int i = 0; i < 3; i++) begin
            q3_neg_ff[i] <= q2_y_ff[i][YW2-1];
         end
         q3_eye_ff <= q2_eye_ff;
         q3_z_ff   <= q2_z_ff;
         q3_x_ff   <= q2_x_ff;
         q3_deg_ff <= q2_deg_ff;
      end
   end

   // rounding: shift down and restore sign
   logic                 q4_valid_ff;
   logic signed [YW-1:0] q4_y_ff [3];
   logic signed [YW-1:0] q4_y_in [3];
   logic [95:0]          q4_eye_ff;
   logic [3*OW-1:0]      q4_z_ff;
   logic [3*OW-1:0]      q4_x_ff;
   logic                 q4_deg_ff;

   always_comb begin
      logic [YW-1:0] m;
      for (int i = 0; i < 3; i++) begin
         m          = q3_rnd_ff[i][FRAC_BITS +: YW];
         q4_y_in[i] = q3_neg_ff[i] ? -$signed(m) : $signed(m);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q4_valid_ff <= 1'b0;
      end else if (advance) begin
         q4_valid_ff <= q3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q4_y_ff   <= q4_y_in;
         q4_eye_ff <= q3_eye_ff;
         q4_z_ff   <= q3_z_ff;
         q4_x_ff   <= q3_x_ff;
         q4_deg_ff <= q3_deg_ff;
      end
   end

   // row serialiser: holds one finished item; the pipe stalls only once another waits in q4
   logic                 ser_valid_ff;
   row_type              row_ff;
   row_type              row_in;
   logic signed [OW-1:0] ser_x_ff [3];
   logic signed [YW-1:0] ser_y_ff [3];
   logic signed [OW-1:0] ser_z_ff [3];
   logic [95:0]          ser_eye_ff;
   logic                 ser_deg_ff;

   assign load       = !ser_valid_ff || (row_ff == ROW_EYE && rsp_tready);
   assign advance    = !q4_valid_ff || load;
   assign req_tready = advance;

   always_comb begin
      unique case (row_ff)
         ROW_X:   row_in = ROW_Y;
         ROW_Y:   row_in = ROW_Z;
         ROW_Z:   row_in = ROW_EYE;
         ROW_EYE: row_in = ROW_X;
         default: row_in = ROW_X;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         row_ff       <= ROW_X;
      end else if (load) begin
         ser_valid_ff <= q4_valid_ff;
         row_ff       <= ROW_X;
      end else if (rsp_tready) begin
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            ser_x_ff[i] <= $signed(q4_x_ff[i*OW +: OW]);
            ser_z_ff[i] <= $signed(q4_z_ff[i*OW +: OW]);
         end
         ser_y_ff   <= q4_y_ff;
         ser_eye_ff <= q4_eye_ff;
         ser_deg_ff <= q4_deg_ff;
      end
   end

   logic [31:0] col_zero;
   logic [31:0] col_one;
   logic [31:0] col_two;
   logic [16:0] col_three;

   always_comb begin
      col_three = '0;
      unique case (row_ff)
         ROW_X: begin
            col_zero = 32'(ser_x_ff[0]);
            col_one  = 32'(ser_x_ff[1]);
            col_two  = 32'(ser_x_ff[2]);
         end
         ROW_Y: begin
            col_zero = 32'(ser_y_ff[0]);
            col_one  = 32'(ser_y_ff[1]);
            col_two  = 32'(ser_y_ff[2]);
         end
         ROW_Z: begin
            col_zero = 32'(ser_z_ff[0]);
            col_one  = 32'(ser_z_ff[1]);
            col_two  = 32'(ser_z_ff[2]);
         end
         ROW_EYE: begin
            col_zero  = ser_eye_ff[31:0];
            col_one   = ser_eye_ff[63:32];
            col_two   = ser_eye_ff[95:64];
            col_three = UNIT_WIDE[16:0];
         end
         default: begin
            col_zero = '0;
            col_one  = '0;
            col_two  = '0;
         end
      endcase
   end

   assign rsp_tvalid = ser_valid_ff;
   assign rsp_tdata  = {7'd0, col_three, col_two, col_one, col_zero};
   assign rsp_tuser  = {ser_deg_ff, row_ff};
   assign rsp_tlast  = (row_ff == ROW_EYE);

`ifndef SYNTH
   a_row_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && row_ff != ROW_EYE)
      |=> (rsp_tvalid && 2'(row_ff) == 2'(2'($past(row_ff)) + 2'd1)))
      else $error("row order broken inside an item");

   a_deg_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && row_ff != ROW_EYE) |=> $stable(ser_deg_ff))
      else $error("degenerate flag changed inside an item");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (q4_valid_ff && !advance) |=> (q4_valid_ff && rsp_tvalid))
      else $error("finished item lost while output stalled");
`endif

endmodule
